@@ sv/tks_pkg.sv @@
// Shared constants, types and build-time kernel functions for the triangular smoothing filter.
`timescale 1ns / 1ps
`default_nettype none

package tks_pkg;

  localparam int WIN_SIZE_DEF    = 5;
  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int PIXEL_W     = 16;
  localparam int VALUE_W     = 16;
  localparam int ROW_W       = 12;
  localparam int COL_W       = 11;
  localparam int LINE_W_BITS = 12;
  localparam int HEIGHT_BITS = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int WEIGHT_W    = 17;
  localparam int MAX_HEIGHT  = 4096;

  localparam logic [LINE_W_BITS-1:0] LINE_WIDTH_RST   = 12'd2048;
  localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 13'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             emit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pos_t;

  function automatic longint unsigned ceil_root(input longint unsigned v);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << 26;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (mid * mid >= v) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  // restoring long division, used only at elaboration
  function automatic longint unsigned floor_div(input longint unsigned n,
                                                input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((n >> i) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // Q0.16 weight of squared center distance d2
  function automatic logic [WEIGHT_W-1:0] kernel_weight(input int win, input int d2);
    longint unsigned wn;
    longint unsigned hs;
    longint unsigned den;
    longint unsigned num0;
    longint unsigned slope;
    longint unsigned dd;
    wn    = longint'(win);
    hs    = longint'(win >> 1);
    dd    = longint'(d2);
    den   = wn * wn;
    num0  = 64'd65536 * 2 * hs * wn;
    slope = 64'd65536 * 4 * hs * hs;
    if (4 * hs * hs * dd >= den) return '0;
    return WEIGHT_W'(floor_div(num0 - ceil_root(slope * slope * dd), den));
  endfunction

  function automatic longint unsigned weight_sum(input int win);
    int hs;
    longint unsigned s;
    hs = win >> 1;
    s  = 0;
    for (int dy = -hs; dy <= hs; dy++) begin
      for (int dx = -hs; dx <= hs; dx++) begin
        s = s + longint'(kernel_weight(win, dy * dy + dx * dx));
      end
    end
    return s;
  endfunction

  function automatic longint unsigned recip_q(input int win);
    longint unsigned s;
    s = weight_sum(win);
    if (s == 0) return 0;
    return floor_div(64'd1 << 32, s);
  endfunction

endpackage

`default_nettype wire

@@ sv/tks_stream_if.sv @@
// Valid/ready stream interfaces for the pixel input and the filtered result output.
`timescale 1ns / 1ps
`default_nettype none

interface tks_pixel_if;
  import tks_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface tks_result_if;
  import tks_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] filtered_value;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic               last;

  modport source (output valid, output filtered_value, output out_row, output out_col,
                  output last, input ready);
  modport sink (input valid, input filtered_value, input out_row, input out_col,
                input last, output ready);
endinterface

`default_nettype wire

@@ sv/tks_line_buffer.sv @@
// Raster position counters and line memory: lane write per row slot, column read per request.
`timescale 1ns / 1ps
`default_nettype none

module tks_line_buffer #(
  parameter int WIN_SIZE    = tks_pkg::WIN_SIZE_DEF,
  parameter int MAX_WIDTH   = tks_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = tks_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [tks_pkg::LINE_W_BITS-1:0]  line_width,
  input  wire logic [tks_pkg::HEIGHT_BITS-1:0]  frame_height,
  tks_pixel_if.sink                             pixels,
  output logic                                  col_valid,
  input  wire logic                             col_ready,
  output logic [2*(WIN_SIZE/2):0][((SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS)-1:0] col_data,
  output tks_pkg::pos_t                         col_pos
);
  import tks_pkg::*;

  localparam int HALF   = WIN_SIZE / 2;
  localparam int SPAN   = 2 * HALF + 1;
  localparam int SW     = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int CMP_W  = (CW + 1 > LINE_W_BITS) ? CW + 1 : LINE_W_BITS;
  localparam int SLOT_W = $clog2(SPAN);

  logic [CW-1:0]     col_count;
  logic [ROW_W-1:0]  row_count;
  logic [SLOT_W-1:0] row_slot;

  logic [LINE_W_BITS-1:0] eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic [CMP_W-1:0]       cx_ext;
  logic [CMP_W-1:0]       cx_inc;
  logic [CMP_W-1:0]       w_ext;
  logic [HEIGHT_BITS-1:0] ry_ext;
  logic [HEIGHT_BITS-1:0] ry_inc;
  logic                   col_wrap;
  logic                   row_wrap;
  logic                   accept;
  pos_t                   pos_next;

  logic [SPAN-1:0][SW-1:0] mem [MAX_WIDTH];
  logic [SPAN-1:0][SW-1:0] rdata;
  logic [SW-1:0]           a_pix;
  logic [SLOT_W-1:0]       a_slot;

  assign eff_w = (CMP_W'(line_width) > CMP_W'(MAX_WIDTH)) ? LINE_W_BITS'(MAX_WIDTH) : line_width;
  assign eff_h = (frame_height > HEIGHT_BITS'(MAX_HEIGHT)) ? HEIGHT_BITS'(MAX_HEIGHT)
                                                           : frame_height;

  assign cx_ext   = CMP_W'(col_count);
  assign cx_inc   = cx_ext + CMP_W'(1);
  assign w_ext    = CMP_W'(eff_w);
  assign ry_ext   = HEIGHT_BITS'(row_count);
  assign ry_inc   = ry_ext + HEIGHT_BITS'(1);
  assign col_wrap = cx_inc >= w_ext;
  assign row_wrap = ry_inc >= eff_h;

  assign pixels.ready = !col_valid || col_ready;
  assign accept       = pixels.valid && pixels.ready;

  always_comb begin
    pos_next.emit = (row_count >= ROW_W'(2 * HALF)) && (cx_ext >= CMP_W'(2 * HALF)) &&
                    (cx_ext < w_ext) && (ry_ext < eff_h);
    pos_next.row  = row_count - ROW_W'(HALF);
    pos_next.col  = COL_W'(cx_ext - CMP_W'(HALF));
    pos_next.last = (ry_inc == eff_h) && (cx_inc == w_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      row_slot  <= '0;
      col_valid <= 1'b0;
    end else begin
      if (pixels.ready) begin
        col_valid <= pixels.valid;
      end
      if (accept) begin
        if (col_wrap) begin
          col_count <= '0;
          if (row_wrap) begin
            row_count <= '0;
            row_slot  <= '0;
          end else begin
            row_count <= row_count + ROW_W'(1);
            row_slot  <= (row_slot == SLOT_W'(SPAN - 1)) ? '0 : row_slot + SLOT_W'(1);
          end
        end else begin
          col_count <= col_count + CW'(1);
        end
      end
    end
  end

  // read returns the older rows of this column; the lane of the current row is replaced below
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[col_count][row_slot] <= pixels.pixel_in[SW-1:0];
      rdata                    <= mem[col_count];
      a_pix                    <= pixels.pixel_in[SW-1:0];
      a_slot                   <= row_slot;
      col_pos                  <= pos_next;
    end
  end

  // reorder lanes so that index 0 is the top row of the window
  always_comb begin
    logic [SLOT_W:0] lane;
    lane = '0;
    for (int dy = 0; dy < SPAN - 1; dy++) begin
      lane = (SLOT_W + 1)'(a_slot) + (SLOT_W + 1)'(dy + 1);
      if (lane >= (SLOT_W + 1)'(SPAN)) lane = lane - (SLOT_W + 1)'(SPAN);
      col_data[dy] = rdata[lane[SLOT_W-1:0]];
    end
    col_data[SPAN-1] = a_pix;
  end

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (cx_ext < CMP_W'(MAX_WIDTH)) && (row_slot < SLOT_W'(SPAN)))
    else $error("column count or row slot out of range");

  a_slot_tracks_row: assert property (@(posedge clk) disable iff (rst)
    (row_count == '0) |-> (row_slot == '0))
    else $error("row slot not aligned with row count");
`endif

endmodule

`default_nettype wire

@@ sv/tks_kernel_mac.sv @@
// Window registers and pipelined weighted sum: tap multiplies, row sums, window total.
`timescale 1ns / 1ps
`default_nettype none

module tks_kernel_mac #(
  parameter int WIN_SIZE    = tks_pkg::WIN_SIZE_DEF,
  parameter int SAMPLE_BITS = tks_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          col_valid,
  output logic               col_ready,
  input  wire logic [2*(WIN_SIZE/2):0][((SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS)-1:0] col_data,
  input  tks_pkg::pos_t      col_pos,
  output logic               acc_valid,
  input  wire logic          acc_ready,
  output logic [((SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS) + tks_pkg::WEIGHT_W +
                $clog2((2*(WIN_SIZE/2)+1)*(2*(WIN_SIZE/2)+1))-1:0] acc,
  output tks_pkg::pos_t      acc_pos
);
  import tks_pkg::*;

  localparam int HALF  = WIN_SIZE / 2;
  localparam int SPAN  = 2 * HALF + 1;
  localparam int SW    = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam int PW    = SW + WEIGHT_W;
  localparam int RS_W  = PW + $clog2(SPAN);
  localparam int ACC_W = PW + $clog2(SPAN * SPAN);
  localparam longint unsigned SAMPLE_MAX = (64'd1 << SW) - 1;
  localparam longint unsigned ACC_MAX    = SAMPLE_MAX * weight_sum(WIN_SIZE);

  logic [SW-1:0]   window [SPAN][SPAN];
  logic [PW-1:0]   prod   [SPAN][SPAN];
  logic [RS_W-1:0] row_sum      [SPAN];
  logic [RS_W-1:0] row_sum_next [SPAN];
  logic [ACC_W-1:0] acc_next;

  logic b_v, c_v, d_v;
  logic adv_c, adv_d, adv_e;
  logic take_b;
  pos_t b_pos, c_pos, d_pos;

  assign adv_e     = !acc_valid || acc_ready;
  assign adv_d     = !d_v || adv_e;
  assign adv_c     = !c_v || adv_d;
  assign col_ready = !b_v || adv_c;
  assign take_b    = col_valid && col_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      acc_valid <= 1'b0;
    end else begin
      if (col_ready) b_v <= col_valid && col_pos.emit;
      if (adv_c) c_v <= b_v;
      if (adv_d) d_v <= c_v;
      if (adv_e) acc_valid <= d_v;
    end
  end

  // every sample shifts the window, results or not
  always_ff @(posedge clk) begin
    if (take_b) begin
      for (int dx = 0; dx < SPAN - 1; dx++) begin
        for (int dy = 0; dy < SPAN; dy++) begin
          window[dx][dy] <= window[dx+1][dy];
        end
      end
      for (int dy = 0; dy < SPAN; dy++) begin
        window[SPAN-1][dy] <= col_data[dy];
      end
      b_pos <= col_pos;
    end
  end

  for (genvar gy = 0; gy < SPAN; gy++) begin : g_row
    for (genvar gx = 0; gx < SPAN; gx++) begin : g_tap
      localparam logic [WEIGHT_W-1:0] WQ =
        kernel_weight(WIN_SIZE, (gy - HALF) * (gy - HALF) + (gx - HALF) * (gx - HALF));
      always_ff @(posedge clk) begin
        if (adv_c) prod[gy][gx] <= PW'(window[gx][gy]) * PW'(WQ);
      end
    end
  end

  always_comb begin
    for (int dy = 0; dy < SPAN; dy++) begin
      row_sum_next[dy] = '0;
      for (int dx = 0; dx < SPAN; dx++) begin
        row_sum_next[dy] = row_sum_next[dy] + RS_W'(prod[dy][dx]);
      end
    end
  end

  always_comb begin
    acc_next = '0;
    for (int dy = 0; dy < SPAN; dy++) begin
      acc_next = acc_next + ACC_W'(row_sum[dy]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) c_pos <= b_pos;
    if (adv_d) begin
      row_sum <= row_sum_next;
      d_pos   <= c_pos;
    end
    if (adv_e) begin
      acc     <= acc_next;
      acc_pos <= d_pos;
    end
  end

`ifndef SYNTHESIS
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    acc_valid |-> (64'(acc) <= ACC_MAX))
    else $error("weighted sum above full-scale bound");
`endif

endmodule

`default_nettype wire

@@ sv/tks_normalize.sv @@
// Scales the weighted sum by the reciprocal weight total, saturates, and drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module tks_normalize #(
  parameter int WIN_SIZE    = tks_pkg::WIN_SIZE_DEF,
  parameter int SAMPLE_BITS = tks_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     acc_valid,
  output logic          acc_ready,
  input  wire logic [((SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS) + tks_pkg::WEIGHT_W +
                     $clog2((2*(WIN_SIZE/2)+1)*(2*(WIN_SIZE/2)+1))-1:0] acc,
  input  tks_pkg::pos_t acc_pos,
  tks_result_if.source  results
);
  import tks_pkg::*;

  localparam int HALF  = WIN_SIZE / 2;
  localparam int SPAN  = 2 * HALF + 1;
  localparam int SW    = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam int ACC_W = SW + WEIGHT_W + $clog2(SPAN * SPAN);
  localparam int SPLIT = 16;
  localparam longint unsigned RECIP = recip_q(WIN_SIZE);
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PH_W  = ACC_W - SPLIT + RW;
  localparam int PL_W  = SPLIT + RW;
  localparam int SUM_W = ACC_W + RW + 1;
  localparam int QW    = SUM_W - 32;
  localparam logic [SW-1:0] SAMPLE_MAX = '1;

  logic            f_v;
  logic            adv_g;
  logic [PH_W-1:0] p_hi;
  logic [PL_W-1:0] p_lo;
  pos_t            f_pos;
  logic [SUM_W-1:0] full;
  logic [QW-1:0]    quot;
  logic [SW-1:0]    sat;

  assign adv_g     = !results.valid || results.ready;
  assign acc_ready = !f_v || adv_g;

  assign full = (SUM_W'(p_hi) << SPLIT) + SUM_W'(p_lo);
  assign quot = full[SUM_W-1:32];
  assign sat  = (quot > QW'(SAMPLE_MAX)) ? SAMPLE_MAX : quot[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v           <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (acc_ready) f_v <= acc_valid;
      if (adv_g) results.valid <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_ready) begin
      p_hi  <= PH_W'(acc[ACC_W-1:SPLIT]) * PH_W'(RECIP);
      p_lo  <= PL_W'(acc[SPLIT-1:0]) * PL_W'(RECIP);
      f_pos <= acc_pos;
    end
    if (adv_g) begin
      results.filtered_value <= VALUE_W'(sat);
      results.out_row        <= f_pos.row;
      results.out_col        <= f_pos.col;
      results.last           <= f_pos.last;
    end
  end

`ifndef SYNTHESIS
  a_value_saturated: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.filtered_value <= VALUE_W'(SAMPLE_MAX)))
    else $error("filtered value above sample range");
`endif

endmodule

`default_nettype wire

@@ sv/triangular_kernel_smoothing_filter.sv @@
// Triangular-kernel weighted mean filter over a row-major raster stream.
// Usage:
//   pixels  : valid/ready input, one sample per request, row-major order.
//   results : valid/ready output, one request per interior pixel with the weighted
//             mean, the center row and column, and last on the final interior pixel.
//   cfg_*   : write port for line_width (index 0) and frame_height (index 1);
//             write only while no requests are in flight.
// Throughput: one sample per clock unless results holds the pipeline, set by the single
// line memory that is read and lane-written for every sample.
// Path: a window's bottom-right sample passes the column, window, product, row-sum,
// total, scaled and result registers; border pixels produce no result.
// Reset: position counters clear, line_width returns to 2048 and frame_height to
// 1024; the line memory is not cleared and needs no clearing pass.
// Stall: when results is not ready the pipeline holds; pixels stays ready while
// empty pipeline stages remain and drops once every stage is occupied.
`timescale 1ns / 1ps
`default_nettype none

module triangular_kernel_smoothing_filter #(
  parameter int WIN_SIZE    = tks_pkg::WIN_SIZE_DEF,
  parameter int MAX_WIDTH   = tks_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = tks_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [tks_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tks_pkg::CFG_DATA_W-1:0]  cfg_data,
  tks_pixel_if.sink                            pixels,
  tks_result_if.source                         results
);
  import tks_pkg::*;

  localparam int HALF  = WIN_SIZE / 2;
  localparam int SPAN  = 2 * HALF + 1;
  localparam int SW    = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam int ACC_W = SW + WEIGHT_W + $clog2(SPAN * SPAN);

  logic [LINE_W_BITS-1:0] line_width;
  logic [HEIGHT_BITS-1:0] frame_height;

  logic                    col_valid;
  logic                    col_ready;
  logic [SPAN-1:0][SW-1:0] col_data;
  pos_t                    col_pos;
  logic                    acc_valid;
  logic                    acc_ready;
  logic [ACC_W-1:0]        acc;
  pos_t                    acc_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LINE_WIDTH:   line_width   <= cfg_data[LINE_W_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  tks_line_buffer #(
    .WIN_SIZE    (WIN_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line_buffer (
    .clk          (clk),
    .rst          (rst),
    .line_width   (line_width),
    .frame_height (frame_height),
    .pixels       (pixels),
    .col_valid    (col_valid),
    .col_ready    (col_ready),
    .col_data     (col_data),
    .col_pos      (col_pos)
  );

  tks_kernel_mac #(
    .WIN_SIZE    (WIN_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_kernel_mac (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .col_ready (col_ready),
    .col_data  (col_data),
    .col_pos   (col_pos),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .acc       (acc),
    .acc_pos   (acc_pos)
  );

  tks_normalize #(
    .WIN_SIZE    (WIN_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_normalize (
    .clk       (clk),
    .rst       (rst),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .acc       (acc),
    .acc_pos   (acc_pos),
    .results   (results)
  );

endmodule

`default_nettype wire

@@ dv/triangular_kernel_smoothing_filter_test.sv @@
// Self-checking testbench for the triangular-kernel smoothing filter.
`timescale 1ns / 1ps

module triangular_kernel_smoothing_filter_test;
  import tks_pkg::*;

  localparam int HALF        = WIN_SIZE_DEF / 2;
  localparam int SPAN        = 2 * HALF + 1;
  localparam int MAX_D2      = 2 * HALF * HALF;
  localparam longint unsigned SAMPLE_MAX = (64'd1 << SAMPLE_BITS_DEF) - 1;
  localparam int PRESSURE_AT = 420;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_RDY  = 16;

  typedef enum {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_EXTREMES, FILL_WALK} fill_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               last;
  } smoothed_t;

  class mean_scoreboard;
    logic [PIXEL_W-1:0] recent_rows [SPAN][MAX_WIDTH_DEF];
    longint unsigned    weight [MAX_D2+1];
    longint unsigned    recip;
    int unsigned        width_reg;
    int unsigned        height_reg;
    int unsigned        col;
    int unsigned        row;
    smoothed_t          pending_means [$];
    int unsigned        failures;

    function new();
      longint unsigned wn, hs, k, v, root, total;
      wn    = WIN_SIZE_DEF;
      hs    = HALF;
      total = 0;
      // w(d) = 65536 * 2hs * (wn - 2hs*d) / wn^2, zero once d reaches wn/(2hs)
      k = 64'd65536 * 4 * hs * hs;
      for (int d2 = 0; d2 <= MAX_D2; d2++) begin
        if (4 * hs * hs * longint'(d2) >= wn * wn) begin
          weight[d2] = 0;
        end else begin
          v    = k * k * longint'(d2);
          root = longint'($sqrt(real'(v)));
          while (root * root < v) root++;
          while (root > 0 && (root - 1) * (root - 1) >= v) root--;
          weight[d2] = (64'd65536 * 2 * hs * wn - root) / (wn * wn);
        end
      end
      for (int dy = -HALF; dy <= HALF; dy++) begin
        for (int dx = -HALF; dx <= HALF; dx++) total += weight[dy * dy + dx * dx];
      end
      recip = (64'd1 << 32) / total;
      foreach (recent_rows[i, j]) recent_rows[i][j] = '0;
      width_reg  = LINE_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      col        = 0;
      row        = 0;
      failures   = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LINE_WIDTH:   width_reg  = data[LINE_W_BITS-1:0];
        REG_FRAME_HEIGHT: height_reg = data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] px);
      int unsigned     w_eff, h_eff, slot;
      longint unsigned acc, mean;
      smoothed_t       res;
      w_eff = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
      h_eff = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      if (col < MAX_WIDTH_DEF) recent_rows[row % SPAN][col] = px & SAMPLE_MAX;
      if (row >= 2 * HALF && col >= 2 * HALF && col < w_eff && row < h_eff) begin
        acc = 0;
        for (int dy = 0; dy < SPAN; dy++) begin
          slot = (row - 2 * HALF + dy) % SPAN;
          for (int dx = 0; dx < SPAN; dx++) begin
            acc += longint'(recent_rows[slot][col - 2 * HALF + dx])
                   * weight[(dy - HALF) * (dy - HALF) + (dx - HALF) * (dx - HALF)];
          end
        end
        mean = (acc * recip) >> 32;
        if (mean > SAMPLE_MAX) mean = SAMPLE_MAX;
        res.value = mean[VALUE_W-1:0];
        res.row   = ROW_W'(row - HALF);
        res.col   = COL_W'(col - HALF);
        res.last  = (row + 1 == h_eff) && (col + 1 == w_eff);
        pending_means.push_back(res);
      end
      col++;
      if (col >= w_eff) begin
        col = 0;
        row++;
        if (row >= h_eff) row = 0;
      end
    endfunction

    function void check_result(logic [VALUE_W-1:0] value, logic [ROW_W-1:0] r,
                               logic [COL_W-1:0] c, logic l);
      smoothed_t want;
      if (pending_means.size() == 0) begin
        $error("result with none pending: filtered_value %0d out_row %0d out_col %0d",
               value, r, c);
        failures++;
        return;
      end
      want = pending_means.pop_front();
      if (value !== want.value) begin
        $error("filtered_value: expected %0d, actual %0d", want.value, value);
        failures++;
      end
      if (r !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, r);
        failures++;
      end
      if (c !== want.col) begin
        $error("out_col: expected %0d, actual %0d", want.col, c);
        failures++;
      end
      if (l !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, l);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return pending_means.size();
    endfunction

    function bit at_frame_start();
      return (col == 0) && (row == 0);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tks_pixel_if  pixels ();
  tks_result_if results ();

  triangular_kernel_smoothing_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels),
    .results   (results)
  );

  mean_scoreboard sb = new();
  int unsigned    pixels_taken = 0;
  int unsigned    src_calm = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones, and now and then a gap-free stretch
  function automatic int unsigned random_gap(inout int unsigned calm);
    int unsigned pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(0, 999);
    if (pick < 5) begin
      calm = $urandom_range(50, 300);
      return 0;
    end
    if (pick < 600) return 0;
    if (pick < 930) return $urandom_range(1, 3);
    if (pick < 990) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [PIXEL_W-1:0] next_pixel(fill_t style);
    case (style)
      FILL_MAX:      return '1;
      FILL_ZERO:     return '0;
      FILL_EXTREMES: return $urandom_range(0, 1) ? '1 : '0;
      FILL_WALK:     return PIXEL_W'(1) << $urandom_range(0, PIXEL_W - 1);
      default:       return PIXEL_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    int unsigned gap;
    gap = random_gap(src_calm);
    if (gap > 0) begin
      pixels.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixels.valid    <= 1'b1;
    pixels.pixel_in <= px;
    @(posedge clk);
    while (!pixels.ready) @(posedge clk);
    sb.note_pixel(px);
    pixels_taken++;
  endtask

  // drain: nothing pending, then enough cycles with the output open for bubbles to clear
  task automatic settle();
    int unsigned open_cycles;
    pixels.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    open_cycles = 0;
    while (open_cycles < SETTLE_RDY) begin
      @(posedge clk);
      if (results.ready) open_cycles++;
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    settle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_register(idx, data);
  endtask

  task automatic feed(int unsigned count, fill_t style);
    repeat (count) send_pixel(next_pixel(style));
  endtask

  task automatic finish_frame(fill_t style);
    while (!sb.at_frame_start()) send_pixel(next_pixel(style));
  endtask

  task automatic run_frames(int unsigned w, int unsigned h, int unsigned count, fill_t style);
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    feed(count, style);
    finish_frame(style);
  endtask

  always @(posedge clk) begin
    if (results.valid && results.ready) begin
      sb.check_result(results.filtered_value, results.out_row, results.out_col, results.last);
    end
  end

  initial begin : result_sink
    int unsigned hold;
    int unsigned calm;
    bit          pressured;
    hold      = 0;
    calm      = 0;
    pressured = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      // one long back-pressure stretch while the large frame is streaming
      if (!pressured && pixels_taken >= PRESSURE_AT) begin
        pressured = 1;
        hold      = 400;
      end
      if (hold > 0) begin
        results.ready <= 1'b0;
        hold--;
      end else begin
        results.ready <= 1'b1;
        hold = random_gap(calm);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pixels.valid && pixels.ready) || (results.valid && results.ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned w, h, n, pick;
    fill_t       style;
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= REG_LINE_WIDTH;
    cfg_data        <= '0;
    pixels.valid    <= 1'b0;
    pixels.pixel_in <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // smallest frame with one result: full scale and zero, then a 6x6 frame of extremes
    run_frames(5, 5, 25, FILL_MAX);
    run_frames(5, 5, 25, FILL_ZERO);
    run_frames(6, 6, 36, FILL_EXTREMES);

    // geometry too small for a window, including zero width and height, then a 5x5 walking-bit frame
    run_frames(0, 0, 4, FILL_RANDOM);
    run_frames(0, 3, 6, FILL_RANDOM);
    run_frames(3, 0, 6, FILL_RANDOM);
    run_frames(3, 3, 9, FILL_RANDOM);
    run_frames(4, 4, 16, FILL_RANDOM);
    run_frames(2, 7, 14, FILL_RANDOM);
    run_frames(1, 1, 2, FILL_RANDOM);
    run_frames(5, 5, 25, FILL_WALK);

    // height changed mid-block, below and above the current row
    write_reg(REG_LINE_WIDTH, 7);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    feed(70, FILL_RANDOM);
    write_reg(REG_FRAME_HEIGHT, 6);
    finish_frame(FILL_RANDOM);
    write_reg(REG_FRAME_HEIGHT, 8);
    feed(21, FILL_RANDOM);
    write_reg(REG_FRAME_HEIGHT, 9);
    finish_frame(FILL_RANDOM);

    // large frame, streamed while the receiver holds off
    run_frames(24, 12, 288, FILL_RANDOM);

    random_items = 0;
    while (random_items < 1400) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        w = $urandom_range(0, 4);
        h = $urandom_range(0, 6);
      end else if (pick < 10) begin
        w = $urandom_range(32, 64);
        h = 5;
      end else begin
        w = $urandom_range(5, 24);
        h = $urandom_range(5, 12);
      end
      case ($urandom_range(0, 9))
        7:       style = FILL_EXTREMES;
        8:       style = FILL_WALK;
        9:       style = FILL_MAX;
        default: style = FILL_RANDOM;
      endcase
      n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 2);
      run_frames(w, h, n, style);
      random_items += n;
    end

    settle();
    if (sb.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tks_pkg.sv
sv/tks_stream_if.sv
sv/tks_line_buffer.sv
sv/tks_kernel_mac.sv
sv/tks_normalize.sv
sv/triangular_kernel_smoothing_filter.sv
dv/triangular_kernel_smoothing_filter_test.sv
